// File: design/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants and the CORDIC arctangent table for the frame composer.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // cos/sin and multiplier coefficient width, signed Q2.30 plus headroom
  localparam int CS_W = 33;
  // CORDIC residual angle width, signed 32-bit turns plus sign
  localparam int Z_W = 33;
  localparam int SPIN_W = 32;
  localparam int TURN_W = 32;

  // CORDIC gain 0.60725 in Q2.30
  localparam logic signed [CS_W-1:0] CORDIC_X0 = 33'sd652032874;

  typedef logic signed [CS_W-1:0] coef_t;
  typedef logic signed [Z_W-1:0] zang_t;

  // arctan(2^-k) in 32-bit binary turns
  function automatic logic [TURN_W-1:0] atan_turns(input logic [4:0] k);
    logic [TURN_W-1:0] v;
    case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: design/planar_frame_composer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_frame_composer
// Composes a local planar kinematic state into its reference frame.
// ----------------------------------------------------------------------------
// Pipeline: one register per CORDIC iteration, then partial products, product
//   combine, sum and round, saturate.
// Throughput: one transfer per cycle; the whole pipeline holds while the
//   output register is full and out_tready is low.
// Reset: rst_n (synchronous, active low) clears all valid bits; data is not reset.
module planar_frame_composer #(
  parameter int POS_WIDTH   = 48,
  parameter int ANGLE_WIDTH = 32,
  parameter int TRIG_STAGES = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // ref_origin_x, ref_origin_y, ref_vel_x, ref_vel_y, ref_angle, ref_spin,
  // loc_origin_x, loc_origin_y, loc_vel_x, loc_vel_y, loc_angle, loc_spin
  input  logic [((8*POS_WIDTH+2*ANGLE_WIDTH+2*pfc_pkg::SPIN_W+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // out_origin_x, out_origin_y, out_vel_x, out_vel_y, out_angle, out_spin
  output logic [((4*POS_WIDTH+ANGLE_WIDTH+pfc_pkg::SPIN_W+7)/8)*8-1:0] out_tdata
);
  import pfc_pkg::*;

  localparam int P      = POS_WIDTH;
  localparam int A      = ANGLE_WIDTH;
  localparam int DEPTH  = TRIG_STAGES + 4;
  localparam int SIDE_W = 8 * P + 2;
  localparam int TAIL_W = A + SPIN_W;
  localparam int OUT_W  = ((4*P + A + SPIN_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (4*P + A + SPIN_W);

  // input field offsets
  localparam int O_RA = 4 * P;
  localparam int O_RS = O_RA + A;
  localparam int O_LO = O_RS + SPIN_W;
  localparam int O_LA = O_LO + 4 * P;
  localparam int O_LS = O_LA + A;

  logic en;
  logic [DEPTH-1:0] v_r;

  logic [A-1:0]          ref_angle, loc_angle;
  logic signed [SPIN_W-1:0] ref_spin, loc_spin, spin_sat;
  logic signed [SPIN_W:0]   spin_sum;
  logic [TURN_W-1:0]     a32;

  coef_t x_w [TRIG_STAGES+1];
  coef_t y_w [TRIG_STAGES+1];
  zang_t z_w [TRIG_STAGES+1];

  logic [SIDE_W-1:0] side_r [TRIG_STAGES];
  logic [TAIL_W-1:0] tail_r [DEPTH];

  logic [SIDE_W-1:0] side_end;
  logic signed [P-1:0] rox, roy, rvx, rvy, lox, loy, lvx, lvy;
  logic signed [P-1:0] zero_pos;
  coef_t c, s, ns, rsp, nrsp, zero_coef;
  logic [1:0] quad;
  logic signed [P-1:0] res_ox, res_oy, res_vx, res_vy;

  assign en        = !v_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  assign ref_angle = in_tdata[O_RA +: A];
  assign ref_spin  = in_tdata[O_RS +: SPIN_W];
  assign loc_angle = in_tdata[O_LA +: A];
  assign loc_spin  = in_tdata[O_LS +: SPIN_W];

  assign spin_sum = {ref_spin[SPIN_W-1], ref_spin} + {loc_spin[SPIN_W-1], loc_spin};
  assign spin_sat = (spin_sum[SPIN_W] == spin_sum[SPIN_W-1]) ? spin_sum[SPIN_W-1:0]
                  : {spin_sum[SPIN_W], {(SPIN_W-1){~spin_sum[SPIN_W]}}};

  // scale the angle to 32-bit turns; top two bits pick the quadrant
  assign a32    = TURN_W'(ref_angle) << (TURN_W - A);
  assign x_w[0] = CORDIC_X0;
  assign y_w[0] = '0;
  assign z_w[0] = $signed({3'b000, a32[TURN_W-3:0]});

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
    pfc_cordic_stage #(.SHIFT(i)) u_stage (
      .clk (clk),
      .en  (en),
      .x_i (x_w[i]),
      .y_i (y_w[i]),
      .z_i (z_w[i]),
      .x_o (x_w[i+1]),
      .y_o (y_w[i+1]),
      .z_o (z_w[i+1])
    );
  end

  // positions and quadrant travel beside the CORDIC; the composed angle and spin go in the tail
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= {a32[TURN_W-1:TURN_W-2], in_tdata[O_LO +: 4*P], in_tdata[4*P-1:0]};
      for (int k = 1; k < TRIG_STAGES; k++) side_r[k] <= side_r[k-1];
      tail_r[0] <= {spin_sat, A'(ref_angle + loc_angle)};
      for (int k = 1; k < DEPTH; k++) tail_r[k] <= tail_r[k-1];
    end
  end

  // ref_spin travels beside the CORDIC in its own delay line, separate from the side word
  logic signed [SPIN_W-1:0] rsp_r [TRIG_STAGES];
  always_ff @(posedge clk) begin
    if (en) begin
      rsp_r[0] <= ref_spin;
      for (int k = 1; k < TRIG_STAGES; k++) rsp_r[k] <= rsp_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_tvalid};
    end
  end

  assign side_end = side_r[TRIG_STAGES-1];
  assign rox  = side_end[0*P +: P];
  assign roy  = side_end[1*P +: P];
  assign rvx  = side_end[2*P +: P];
  assign rvy  = side_end[3*P +: P];
  assign lox  = side_end[4*P +: P];
  assign loy  = side_end[5*P +: P];
  assign lvx  = side_end[6*P +: P];
  assign lvy  = side_end[7*P +: P];
  assign quad = side_end[8*P +: 2];

  always_comb begin
    case (quad)
      2'd0:    begin c = x_w[TRIG_STAGES];  s = y_w[TRIG_STAGES];  end
      2'd1:    begin c = -y_w[TRIG_STAGES]; s = x_w[TRIG_STAGES];  end
      2'd2:    begin c = -x_w[TRIG_STAGES]; s = -y_w[TRIG_STAGES]; end
      default: begin c = y_w[TRIG_STAGES];  s = -x_w[TRIG_STAGES]; end
    endcase
  end

  assign ns        = -s;
  assign rsp       = CS_W'(rsp_r[TRIG_STAGES-1]);
  assign nrsp      = -rsp;
  assign zero_coef = '0;
  assign zero_pos  = '0;

  pfc_coord #(.POS_WIDTH(P)) u_origin_x (
    .clk(clk), .en(en), .ref_i(rox),
    .ca_i(c), .pa_i(lox), .cb_i(ns), .pb_i(loy), .cs_i(zero_coef), .ps_i(zero_pos),
    .res_o(res_ox)
  );
  pfc_coord #(.POS_WIDTH(P)) u_origin_y (
    .clk(clk), .en(en), .ref_i(roy),
    .ca_i(s), .pa_i(lox), .cb_i(c), .pb_i(loy), .cs_i(zero_coef), .ps_i(zero_pos),
    .res_o(res_oy)
  );
  pfc_coord #(.POS_WIDTH(P)) u_vel_x (
    .clk(clk), .en(en), .ref_i(rvx),
    .ca_i(c), .pa_i(lvx), .cb_i(ns), .pb_i(lvy), .cs_i(nrsp), .ps_i(loy),
    .res_o(res_vx)
  );
  pfc_coord #(.POS_WIDTH(P)) u_vel_y (
    .clk(clk), .en(en), .ref_i(rvy),
    .ca_i(s), .pa_i(lvx), .cb_i(c), .pb_i(lvy), .cs_i(rsp), .ps_i(lox),
    .res_o(res_vy)
  );

  assign out_tvalid = v_r[DEPTH-1];
  if (OUT_PAD > 0) begin : g_pad
    assign out_tdata = {{OUT_PAD{1'b0}}, tail_r[DEPTH-1], res_vy, res_vx, res_oy, res_ox};
  end else begin : g_nopad
    assign out_tdata = {tail_r[DEPTH-1], res_vy, res_vx, res_oy, res_ox};
  end

  // the pipeline only holds when a finished result waits at the output
  assert property (@(posedge clk) !in_tready |-> out_tvalid && !out_tready)
    else $error("pipeline stalled without a blocked output");
  // an accepted transfer enters the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted transfer lost at pipeline entry");
  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

// File: design/pfc_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_cordic_stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
module pfc_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              en,
  input  pfc_pkg::coef_t    x_i,
  input  pfc_pkg::coef_t    y_i,
  input  pfc_pkg::zang_t    z_i,
  output pfc_pkg::coef_t    x_o,
  output pfc_pkg::coef_t    y_o,
  output pfc_pkg::zang_t    z_o
);
  import pfc_pkg::*;

  coef_t x_r, y_r, dx, dy;
  zang_t z_r, da;

  assign dx = y_i >>> SHIFT;
  assign dy = x_i >>> SHIFT;
  assign da = $signed({1'b0, atan_turns(5'(SHIFT))});

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[Z_W-1]) begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        z_r <= z_i - da;
      end else begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        z_r <= z_i + da;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// File: design/pfc_coord.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_coord
// Four-stage multiply-accumulate for one output coordinate:
// ref<<30 + ca*pa + cb*pb + (cs*ps)<<6, rounded at bit 30 and saturated.
// ----------------------------------------------------------------------------
module pfc_coord #(
  parameter int POS_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [POS_WIDTH-1:0] ref_i,
  input  pfc_pkg::coef_t              ca_i,
  input  logic signed [POS_WIDTH-1:0] pa_i,
  input  pfc_pkg::coef_t              cb_i,
  input  logic signed [POS_WIDTH-1:0] pb_i,
  input  pfc_pkg::coef_t              cs_i,
  input  logic signed [POS_WIDTH-1:0] ps_i,
  output logic signed [POS_WIDTH-1:0] res_o
);
  import pfc_pkg::*;

  localparam int L     = POS_WIDTH / 2;
  localparam int H     = POS_WIDTH - L;
  localparam int LO_W  = CS_W + L + 1;
  localparam int HI_W  = CS_W + H;
  localparam int PW    = POS_WIDTH + CS_W;
  localparam int ACC_W = POS_WIDTH + CS_W + 8;
  localparam int SH_W  = ACC_W - 30;

  coef_t                       coef [3];
  logic signed [POS_WIDTH-1:0] pos  [3];

  logic signed [LO_W-1:0]      plo_r [3];
  logic signed [HI_W-1:0]      phi_r [3];
  logic signed [PW-1:0]        prod_r [3];
  logic signed [POS_WIDTH-1:0] ref1_r, ref2_r, res_r;
  logic signed [ACC_W-1:0]     acc;
  logic signed [SH_W-1:0]      sh_r;
  logic                        fits;

  assign coef[0] = ca_i;
  assign coef[1] = cb_i;
  assign coef[2] = cs_i;
  assign pos[0]  = pa_i;
  assign pos[1]  = pb_i;
  assign pos[2]  = ps_i;

  // split each position so no single multiplier exceeds about 33 x 33
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j]  <= LO_W'(coef[j] * $signed({1'b0, pos[j][L-1:0]}));
        phi_r[j]  <= HI_W'(coef[j] * $signed(pos[j][POS_WIDTH-1:L]));
        prod_r[j] <= (PW'(phi_r[j]) <<< L) + PW'(plo_r[j]);
      end
      ref1_r <= ref_i;
      ref2_r <= ref1_r;
      sh_r   <= SH_W'(acc >>> 30);
      res_r  <= fits ? POS_WIDTH'(sh_r)
                     : {sh_r[SH_W-1], {(POS_WIDTH-1){~sh_r[SH_W-1]}}};
    end
  end

  assign acc = (ACC_W'(ref2_r) <<< 30) + ACC_W'(prod_r[0]) + ACC_W'(prod_r[1])
             + (ACC_W'(prod_r[2]) <<< 6) + (ACC_W'(1) <<< 29);

  assign fits = (sh_r[SH_W-1:POS_WIDTH-1] == '0) || (sh_r[SH_W-1:POS_WIDTH-1] == '1);
  assign res_o = res_r;

endmodule
